// ===== src/xenc_pkg.sv =====
package xenc_pkg;

	// Instruction kinds carried in the mode field.
	localparam logic [4:0] MODE_LABEL    = 5'd0;
	localparam logic [4:0] MODE_LEA_MR   = 5'd1;
	localparam logic [4:0] MODE_MOV_RM   = 5'd2;
	localparam logic [4:0] MODE_JMP_REL  = 5'd3;
	localparam logic [4:0] MODE_MOV_MR   = 5'd4;
	localparam logic [4:0] MODE_PUSH     = 5'd5;
	localparam logic [4:0] MODE_MOV_RR   = 5'd6;
	localparam logic [4:0] MODE_SUB_IMM  = 5'd7;
	localparam logic [4:0] MODE_ADD_IMM  = 5'd8;
	localparam logic [4:0] MODE_POP      = 5'd9;
	localparam logic [4:0] MODE_LEAVE    = 5'd10;
	localparam logic [4:0] MODE_RET      = 5'd11;
	localparam logic [4:0] MODE_JMP_REG  = 5'd12;
	localparam logic [4:0] MODE_JE_REL   = 5'd13;
	localparam logic [4:0] MODE_OR_RR    = 5'd14;
	localparam logic [4:0] MODE_MOV_IMM  = 5'd15;
	localparam logic [4:0] MODE_CALL_REG = 5'd16;

	// Opcode and prefix bytes.
	localparam logic [7:0] OPC_LEA      = 8'h8D;
	localparam logic [7:0] OPC_MOV_STORE = 8'h89;
	localparam logic [7:0] OPC_JMP_REL  = 8'hE9;
	localparam logic [7:0] OPC_MOV_LOAD = 8'h8B;
	localparam logic [7:0] OPC_ALU_IMM  = 8'h81;
	localparam logic [7:0] OPC_LEAVE    = 8'hC9;
	localparam logic [7:0] OPC_RET      = 8'hC3;
	localparam logic [7:0] OPC_GRP5     = 8'hFF;
	localparam logic [7:0] OPC_ESC      = 8'h0F;
	localparam logic [7:0] OPC_JE_REL   = 8'h84;
	localparam logic [7:0] OPC_OR       = 8'h0B;
	localparam logic [7:0] OPC_MOV_IMM  = 8'hB8;
	localparam logic [7:0] OPC_PUSH     = 8'h50;
	localparam logic [7:0] OPC_POP      = 8'h58;
	localparam logic [7:0] REX_B        = 8'h41;
	localparam logic [7:0] REX_W        = 8'h48;
	localparam logic [7:0] SIB_RSP_BASE = 8'h24;

	// ModRM.reg opcode extensions.
	localparam logic [3:0] EXT_ADD  = 4'd0;
	localparam logic [3:0] EXT_CALL = 4'd2;
	localparam logic [3:0] EXT_JMP  = 4'd4;
	localparam logic [3:0] EXT_SUB  = 4'd5;

	// Longest instruction is mov imm64 with ten bytes.
	localparam int DESC_BYTES  = 10;
	localparam int LEN_W       = 4;
	localparam int QUEUE_DEPTH = 2;

	// One classified instruction, ready for serialization.
	typedef struct packed {
		logic [DESC_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]           len;
		logic                       is_label;
	} desc_t;

endpackage

// ===== src/xenc_front.sv =====
module xenc_front
	import xenc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  mode,
	input  logic [3:0]  reg_operand,
	input  logic [3:0]  rm_operand,
	input  logic [63:0] value,
	output logic        q_push,
	input  logic        q_full,
	output desc_t       q_desc
);

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} hdr_t;

	// REX, opcode, ModRM and an optional SIB for register and memory forms.
	function automatic hdr_t modrm_form(input logic [7:0] opc, input logic [3:0] regf,
		input logic [3:0] rmf, input logic mem, input logic wide);
		hdr_t h;
		h.b    = '0;
		h.b[0] = {4'h4, wide, regf[3], 1'b0, rmf[3]};
		h.b[1] = opc;
		h.b[2] = {(mem ? 2'b10 : 2'b11), regf[2:0], rmf[2:0]};
		h.n    = 3'd3;
		if (mem && rmf[2:0] == 3'd4) begin
			h.b[3] = SIB_RSP_BASE;
			h.n    = 3'd4;
		end
		return h;
	endfunction

	// Optional REX.B followed by an opcode that carries the register.
	function automatic hdr_t short_form(input logic [7:0] opc, input logic [3:0] regf);
		hdr_t h;
		h.b = '0;
		if (regf[3]) begin
			h.b[0] = REX_B;
			h.b[1] = opc + {5'd0, regf[2:0]};
			h.n    = 3'd2;
		end else begin
			h.b[0] = opc + {5'd0, regf[2:0]};
			h.n    = 3'd1;
		end
		return h;
	endfunction

	hdr_t       hdr;
	logic [3:0] nval;
	logic       known;
	logic       label;
	desc_t      desc;
	logic       accept;
	logic       valid_s1;
	desc_t      desc_s1;

	// Classify the instruction into header bytes and an immediate length.
	always_comb begin
		hdr   = '0;
		nval  = 4'd0;
		known = 1'b1;
		label = 1'b0;
		unique case (mode)
			MODE_LABEL: label = 1'b1;
			MODE_LEA_MR: begin
				hdr  = modrm_form(OPC_LEA, reg_operand, rm_operand, 1'b1, 1'b1);
				nval = 4'd4;
			end
			MODE_MOV_RM: begin
				hdr  = modrm_form(OPC_MOV_STORE, reg_operand, rm_operand, 1'b1, 1'b1);
				nval = 4'd4;
			end
			MODE_JMP_REL: begin
				hdr.b[0] = OPC_JMP_REL;
				hdr.n    = 3'd1;
				nval     = 4'd4;
			end
			MODE_MOV_MR: begin
				hdr  = modrm_form(OPC_MOV_LOAD, reg_operand, rm_operand, 1'b1, 1'b1);
				nval = 4'd4;
			end
			MODE_PUSH: hdr = short_form(OPC_PUSH, reg_operand);
			MODE_MOV_RR: hdr = modrm_form(OPC_MOV_LOAD, reg_operand, rm_operand, 1'b0, 1'b1);
			MODE_SUB_IMM: begin
				hdr  = modrm_form(OPC_ALU_IMM, EXT_SUB, rm_operand, 1'b0, 1'b1);
				nval = 4'd4;
			end
			MODE_ADD_IMM: begin
				hdr  = modrm_form(OPC_ALU_IMM, EXT_ADD, rm_operand, 1'b0, 1'b1);
				nval = 4'd4;
			end
			MODE_POP: hdr = short_form(OPC_POP, reg_operand);
			MODE_LEAVE: begin
				hdr.b[0] = OPC_LEAVE;
				hdr.n    = 3'd1;
			end
			MODE_RET: begin
				hdr.b[0] = OPC_RET;
				hdr.n    = 3'd1;
			end
			MODE_JMP_REG: hdr = modrm_form(OPC_GRP5, EXT_JMP, rm_operand, 1'b0, 1'b0);
			MODE_JE_REL: begin
				hdr.b[0] = OPC_ESC;
				hdr.b[1] = OPC_JE_REL;
				hdr.n    = 3'd2;
				nval     = 4'd4;
			end
			MODE_OR_RR: hdr = modrm_form(OPC_OR, reg_operand, rm_operand, 1'b0, 1'b1);
			MODE_MOV_IMM: begin
				hdr.b[0] = REX_W | {7'd0, reg_operand[3]};
				hdr.b[1] = OPC_MOV_IMM + {5'd0, reg_operand[2:0]};
				hdr.n    = 3'd2;
				nval     = 4'd8;
			end
			MODE_CALL_REG: hdr = modrm_form(OPC_GRP5, EXT_CALL, rm_operand, 1'b0, 1'b0);
			default: known = 1'b0;
		endcase
	end

	// Lay out the header followed by the little-endian immediate.
	always_comb begin
		logic [3:0] k;
		desc          = '0;
		desc.is_label = label;
		desc.len      = label ? 4'd1 : ({1'b0, hdr.n} + nval);
		for (int i = 0; i < DESC_BYTES; i++) begin
			k = 4'(i) - {1'b0, hdr.n};
			if (label) begin
				desc.bytes[i] = 8'd0;
			end else if (4'(i) < {1'b0, hdr.n}) begin
				desc.bytes[i] = hdr.b[2'(i)];
			end else begin
				desc.bytes[i] = value[{k[2:0], 3'b000} +: 8];
			end
		end
	end

	// Front stage register; unknown kinds are taken and dropped here.
	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_desc = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= known;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc;
		end
	end

endmodule

// ===== src/xenc_fifo.sv =====
module xenc_fifo
	import xenc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  desc_t wr_desc,
	output logic  is_full,
	input  logic  rd,
	output desc_t rd_desc,
	output logic  is_empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	desc_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign is_full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign is_empty = count_q == '0;
	assign do_wr    = wr && !is_full;
	assign do_rd    = rd && !is_empty;
	assign rd_desc  = mem_q[rd_ptr_q];

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule

// ===== src/xenc_back.sv =====
module xenc_back
	import xenc_pkg::*;
#(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  desc_t       head,
	input  logic        head_valid,
	output logic        head_done,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  code_byte,
	output logic [31:0] byte_offset,
	output logic        is_label,
	output logic        last
);

	logic [LEN_W-1:0]        idx_q;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic                    out_valid_q;
	logic                    advance;
	logic                    emit;
	logic                    final_byte;

	assign advance    = !out_valid_q || pop;
	assign emit       = advance && head_valid;
	assign final_byte = idx_q == head.len - 1'b1;
	assign head_done  = emit && final_byte;
	assign empty      = !out_valid_q;

	// Byte index and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				idx_q <= final_byte ? '0 : idx_q + 1'b1;
				if (!head.is_label) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// Output register holds one result until its transfer.
	always_ff @(posedge clk) begin
		if (emit) begin
			code_byte   <= head.bytes[idx_q];
			byte_offset <= 32'(pos_q);
			is_label    <= head.is_label;
			last        <= final_byte;
		end
	end

endmodule

// ===== src/x86_64_subset_instruction_encoder.sv =====
// The first byte of an item passes the front register, a queue entry and the output register.
// Throughput: one result per cycle while pop is held; an item has 1 to 10 bytes, all sent through
// the single byte-wide output register. Kinds with no encoding are taken at the input and dropped.
// A two-entry queue between the decoder and the serializer lets either side stall.
// Reset (arst_n low) empties all stages and clears the byte position to zero.
module x86_64_subset_instruction_encoder
	import xenc_pkg::*;
#(
	parameter int OFFSET_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  mode,
	input  logic [3:0]  reg_operand,
	input  logic [3:0]  rm_operand,
	input  logic [63:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  code_byte,
	output logic [31:0] byte_offset,
	output logic        is_label,
	output logic        last
);

	logic  q_push;
	logic  q_full;
	desc_t q_wr_desc;
	desc_t q_rd_desc;
	logic  q_empty;
	logic  q_pop;

	// Decode into a byte descriptor.
	xenc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.reg_operand (reg_operand),
		.rm_operand  (rm_operand),
		.value       (value),
		.q_push      (q_push),
		.q_full      (q_full),
		.q_desc      (q_wr_desc)
	);

	// Decouple the decoder from the serializer.
	xenc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wr_desc  (q_wr_desc),
		.is_full  (q_full),
		.rd       (q_pop),
		.rd_desc  (q_rd_desc),
		.is_empty (q_empty)
	);

	// Emit bytes one at a time with their offsets.
	xenc_back #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_rd_desc),
		.head_valid  (!q_empty),
		.head_done   (q_pop),
		.empty       (empty),
		.pop         (pop),
		.code_byte   (code_byte),
		.byte_offset (byte_offset),
		.is_label    (is_label),
		.last        (last)
	);

endmodule

// ===== src/xenc_checker.sv =====
module xenc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  code_byte,
	input logic [31:0] byte_offset,
	input logic        is_label,
	input logic        last
);

	// A label result is a single zero byte that ends its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_label |-> last && code_byte == 8'd0)
		else $error("label result is not a single zero result");

	// After a code byte transfer, the next result sits one position further on.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !is_label |=>
		empty || byte_offset == $past(byte_offset) + 32'd1 || byte_offset == 32'd0)
		else $error("byte offset did not advance by one");

	// A label does not move the position.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && is_label |=> empty || byte_offset == $past(byte_offset))
		else $error("label moved the byte offset");

	// A waiting result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(code_byte) && $stable(byte_offset)
		&& $stable(is_label) && $stable(last))
		else $error("waiting result changed before transfer");

endmodule

bind x86_64_subset_instruction_encoder xenc_checker u_xenc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.code_byte   (code_byte),
	.byte_offset (byte_offset),
	.is_label    (is_label),
	.last        (last)
);

// ===== verif/tb_x86_64_subset_instruction_encoder.sv =====
module tb_x86_64_subset_instruction_encoder;
	import xenc_pkg::*;

	// Kinds above the last defined one encode to nothing.
	localparam logic [4:0] MODE_UNUSED_LO = 5'd17;
	localparam logic [4:0] MODE_UNUSED_HI = 5'd31;
	localparam logic [7:0] REX_BASE       = 8'h40;
	localparam logic [1:0] MOD_MEM_DISP32 = 2'b10;
	localparam logic [1:0] MOD_REG        = 2'b11;
	localparam logic [2:0] RM_NEEDS_SIB   = 3'd4;
	localparam int         RANDOM_ITEMS   = 406;
	localparam int         LONG_HOLD      = 400;
	localparam int         TAIL_CYCLES    = 8;

	// One instruction item, with the byte sequence typed in for rows that carry one.
	typedef struct packed {
		logic [4:0]  kind;
		logic [3:0]  reg_num;
		logic [3:0]  rm_num;
		logic [63:0] val;
		logic        typed;
		logic        lab;
		logic [3:0]  nbytes;
		logic [79:0] bytes;
	} stim_row_t;

	// One result as it should appear on the output ports.
	typedef struct packed {
		logic [7:0]  code;
		logic [31:0] offset;
		logic        lab;
		logic        fin;
	} emit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [4:0]  mode = '0;
	logic [3:0]  reg_operand = '0;
	logic [3:0]  rm_operand = '0;
	logic [63:0] value = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  code_byte;
	logic [31:0] byte_offset;
	logic        is_label;
	logic        last;

	stim_row_t   directed_rows[$];
	emit_t       pending_emits[$];
	logic [7:0]  enc_buf[10];
	int          enc_len;
	bit          enc_label;
	logic [31:0] code_position = '0;
	int          fail_count = 0;
	int          checked_count = 0;
	int          sent_count = 0;
	int          ignored_count = 0;
	int          full_stalls = 0;
	int          long_holds = 0;
	int          send_calm = 0;
	int          recv_calm = 0;
	bit          long_hold_req = 1'b0;

	x86_64_subset_instruction_encoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.reg_operand (reg_operand),
		.rm_operand  (rm_operand),
		.value       (value),
		.empty       (empty),
		.pop         (pop),
		.code_byte   (code_byte),
		.byte_offset (byte_offset),
		.is_label    (is_label),
		.last        (last)
	);

	always #1 clk = ~clk;

	// Guard against a hung handshake.
	initial begin
		#3_000_000;
		$display("x86_64_subset_instruction_encoder regression: fail");
		$finish;
	end

	// Gap before the next transfer: mostly none or short, rarely long, with calm runs.
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void put_byte(logic [7:0] b);
		enc_buf[enc_len] = b;
		enc_len++;
	endfunction

	function automatic void put_le(logic [63:0] v, int count);
		for (int i = 0; i < count; i++)
			put_byte(v[8*i +: 8]);
	endfunction

	// REX, opcode and ModRM, plus the SIB byte when a memory base sits in the RSP slot.
	function automatic void put_modrm(logic [7:0] opc, logic [3:0] r, logic [3:0] m,
			bit mem, bit wide);
		put_byte(REX_BASE | {4'b0, wide, r[3], 1'b0, m[3]});
		put_byte(opc);
		put_byte({mem ? MOD_MEM_DISP32 : MOD_REG, r[2:0], m[2:0]});
		if (mem && m[2:0] == RM_NEEDS_SIB)
			put_byte(SIB_RSP_BASE);
	endfunction

	// Short forms carry the register in the opcode; high registers need REX.B.
	function automatic void put_short(logic [7:0] opc, logic [3:0] r);
		if (r[3])
			put_byte(REX_B);
		put_byte(opc + {5'b0, r[2:0]});
	endfunction

	// Byte sequence of one instruction item into enc_buf.
	function automatic void encode_instr(logic [4:0] kind, logic [3:0] r, logic [3:0] m,
			logic [63:0] v);
		enc_len = 0;
		enc_label = 1'b0;
		case (kind)
			MODE_LABEL: enc_label = 1'b1;
			MODE_LEA_MR: begin
				put_modrm(OPC_LEA, r, m, 1'b1, 1'b1);
				put_le(v, 4);
			end
			MODE_MOV_RM: begin
				put_modrm(OPC_MOV_STORE, r, m, 1'b1, 1'b1);
				put_le(v, 4);
			end
			MODE_JMP_REL: begin
				put_byte(OPC_JMP_REL);
				put_le(v, 4);
			end
			MODE_MOV_MR: begin
				put_modrm(OPC_MOV_LOAD, r, m, 1'b1, 1'b1);
				put_le(v, 4);
			end
			MODE_PUSH: put_short(OPC_PUSH, r);
			MODE_MOV_RR: put_modrm(OPC_MOV_LOAD, r, m, 1'b0, 1'b1);
			MODE_SUB_IMM: begin
				put_modrm(OPC_ALU_IMM, EXT_SUB, m, 1'b0, 1'b1);
				put_le(v, 4);
			end
			MODE_ADD_IMM: begin
				put_modrm(OPC_ALU_IMM, EXT_ADD, m, 1'b0, 1'b1);
				put_le(v, 4);
			end
			MODE_POP: put_short(OPC_POP, r);
			MODE_LEAVE: put_byte(OPC_LEAVE);
			MODE_RET: put_byte(OPC_RET);
			MODE_JMP_REG: put_modrm(OPC_GRP5, EXT_JMP, m, 1'b0, 1'b0);
			MODE_JE_REL: begin
				put_byte(OPC_ESC);
				put_byte(OPC_JE_REL);
				put_le(v, 4);
			end
			MODE_OR_RR: put_modrm(OPC_OR, r, m, 1'b0, 1'b1);
			MODE_MOV_IMM: begin
				put_byte(REX_W | {7'b0, r[3]});
				put_byte(OPC_MOV_IMM + {5'b0, r[2:0]});
				put_le(v, 8);
			end
			MODE_CALL_REG: put_modrm(OPC_GRP5, EXT_CALL, m, 1'b0, 1'b0);
			default: ;
		endcase
	endfunction

	// Turn enc_buf into expected results and advance the code position.
	function automatic void book_results();
		emit_t e;
		if (enc_label) begin
			e = '{code: 8'h00, offset: code_position, lab: 1'b1, fin: 1'b1};
			pending_emits.push_back(e);
		end else begin
			for (int i = 0; i < enc_len; i++) begin
				e = '{code: enc_buf[i], offset: code_position, lab: 1'b0,
					fin: (i == enc_len - 1)};
				pending_emits.push_back(e);
				code_position++;
			end
		end
	endfunction

	function automatic void add_row(logic [4:0] kind, logic [3:0] r, logic [3:0] m,
			logic [63:0] v, bit typed, bit lab, int n, logic [79:0] bytes);
		stim_row_t row;
		row = '{kind: kind, reg_num: r, rm_num: m, val: v, typed: typed, lab: lab,
			nbytes: n[3:0], bytes: bytes};
		directed_rows.push_back(row);
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t row;
		int pick;
		row = '0;
		if ($urandom_range(0, 99) < 5)
			row.kind = $urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI);
		else
			row.kind = $urandom_range(MODE_LABEL, MODE_CALL_REG);
		row.reg_num = $urandom_range(0, 15);
		row.rm_num = $urandom_range(0, 15);
		row.val = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick == 0)
			row.val = '0;
		else if (pick == 1)
			row.val = '1;
		return row;
	endfunction

	// Offer one item, wait for its transfer, then book what it should produce.
	task automatic send_item(stim_row_t row);
		int gap;
		gap = idle_len(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= row.kind;
		reg_operand <= row.reg_num;
		rm_operand <= row.rm_num;
		value <= row.val;
		do begin
			@(posedge clk);
			if (full)
				full_stalls++;
		end while (full);
		if (row.typed) begin
			enc_label = row.lab;
			enc_len = row.nbytes;
			for (int i = 0; i < 10; i++)
				enc_buf[i] = row.bytes[79 - 8*i -: 8];
		end else begin
			encode_instr(row.kind, row.reg_num, row.rm_num, row.val);
		end
		book_results();
		sent_count++;
		if (row.kind > MODE_CALL_REG)
			ignored_count++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_emits.size() != 0);
	endtask

	// Compare one result transfer with the oldest expectation.
	task automatic check_result();
		emit_t e;
		if (pending_emits.size() == 0) begin
			$error("unexpected result: code_byte %h byte_offset %h is_label %b last %b",
				code_byte, byte_offset, is_label, last);
			fail_count++;
		end else begin
			e = pending_emits.pop_front();
			checked_count++;
			if (code_byte !== e.code) begin
				$error("code_byte: expected %h, got %h", e.code, code_byte);
				fail_count++;
			end
			if (byte_offset !== e.offset) begin
				$error("byte_offset: expected %h, got %h", e.offset, byte_offset);
				fail_count++;
			end
			if (is_label !== e.lab) begin
				$error("is_label: expected %b, got %b", e.lab, is_label);
				fail_count++;
			end
			if (last !== e.fin) begin
				$error("last: expected %b, got %b", e.fin, last);
				fail_count++;
			end
		end
	endtask

	// Receiver: random stalls after each transfer, and one long hold on request.
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_result();
				stall_left = idle_len(recv_calm);
			end
			if (long_hold_req) begin
				stall_left = LONG_HOLD;
				long_hold_req = 1'b0;
				long_holds++;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Sender: directed table, a full drain, then random items under a long receiver hold.
	initial begin
		int known;
		known = 0;

		// Rows whose bytes are obvious are typed in; the rest go through the predictor.
		add_row(MODE_LABEL, 4'd0, 4'd0, '0, 1, 1, 0, '0);
		add_row(MODE_RET, 4'd15, 4'd15, '1, 1, 0, 1, {OPC_RET, 72'h0});
		add_row(MODE_LEAVE, 4'd0, 4'd0, '0, 1, 0, 1, {OPC_LEAVE, 72'h0});
		add_row(MODE_UNUSED_LO, 4'd0, 4'd0, '0, 1, 0, 0, '0);
		add_row(MODE_UNUSED_HI, 4'd15, 4'd15, '1, 1, 0, 0, '0);
		add_row(MODE_PUSH, 4'd0, 4'd15, '1, 1, 0, 1, {OPC_PUSH, 72'h0});
		add_row(MODE_PUSH, 4'd15, 4'd0, '0, 1, 0, 2, {REX_B, OPC_PUSH + 8'd7, 64'h0});
		add_row(MODE_POP, 4'd8, 4'd0, '0, 1, 0, 2, {REX_B, OPC_POP, 64'h0});
		add_row(MODE_POP, 4'd7, 4'd0, '0, 1, 0, 1, {OPC_POP + 8'd7, 72'h0});
		add_row(MODE_MOV_IMM, 4'd15, 4'd0, '1, 1, 0, 10,
			{REX_W | 8'h01, OPC_MOV_IMM + 8'd7, {8{8'hFF}}});
		add_row(MODE_MOV_IMM, 4'd0, 4'd15, '0, 1, 0, 10, {REX_W, OPC_MOV_IMM, 64'h0});
		add_row(MODE_LEA_MR, 4'd15, 4'd4, 64'h0000_0000_8000_0000, 0, 0, 0, '0);
		add_row(MODE_MOV_RM, 4'd0, 4'd12, '1, 0, 0, 0, '0);
		add_row(MODE_JMP_REL, 4'd3, 4'd9, 64'h1234_5678_DEAD_BEEF, 0, 0, 0, '0);
		add_row(MODE_MOV_MR, 4'd8, 4'd5, 64'h0000_0000_1234_5678, 0, 0, 0, '0);
		add_row(MODE_MOV_RR, 4'd15, 4'd15, '0, 0, 0, 0, '0);
		add_row(MODE_SUB_IMM, 4'd6, 4'd4, 64'h0000_0000_7FFF_FFFF, 0, 0, 0, '0);
		add_row(MODE_ADD_IMM, 4'd9, 4'd12, '0, 0, 0, 0, '0);
		add_row(MODE_JMP_REG, 4'd15, 4'd0, '1, 0, 0, 0, '0);
		add_row(MODE_JMP_REG, 4'd0, 4'd15, '0, 0, 0, 0, '0);
		add_row(MODE_JE_REL, 4'd0, 4'd0, 64'hFFFF_FFFF_0000_0001, 0, 0, 0, '0);
		add_row(MODE_OR_RR, 4'd3, 4'd11, '0, 0, 0, 0, '0);
		add_row(MODE_CALL_REG, 4'd7, 4'd8, '0, 0, 0, 0, '0);
		add_row(MODE_LABEL, 4'd15, 4'd15, '1, 0, 0, 0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		// Let everything drain before the random part starts.
		push <= 1'b0;
		wait_drained();

		// The receiver now holds off for a long stretch while items keep coming.
		long_hold_req = 1'b1;
		while (known < RANDOM_ITEMS) begin
			stim_row_t row;
			row = random_row();
			send_item(row);
			if (row.kind <= MODE_CALL_REG)
				known++;
		end

		push <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d of unused kinds), checked %0d result transfers.",
			sent_count, ignored_count, checked_count);
		$display("Input held off by full on %0d edges; %0d long receiver hold(s).",
			full_stalls, long_holds);
		if (fail_count == 0)
			$display("x86_64_subset_instruction_encoder regression: pass");
		else
			$display("x86_64_subset_instruction_encoder regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
src/xenc_pkg.sv
src/xenc_front.sv
src/xenc_fifo.sv
src/xenc_back.sv
src/x86_64_subset_instruction_encoder.sv
src/xenc_checker.sv
verif/tb_x86_64_subset_instruction_encoder.sv
